[hw/rtl/pdc_pkg.sv]
// Package for the packet deframer with CRC-32 check.
// Holds the queue entry type, status and header codes and the bytewise CRC-32 update.
// Used by pdc_front, pdc_queue, pdc_back and packet_deframer_crc32_check.
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int unsigned HdrBytes = 12;
  localparam int unsigned HdrIdxW  = 4;

  localparam logic [HdrIdxW-1:0] HDR_TYPE      = 4'd0;
  localparam logic [HdrIdxW-1:0] HDR_LEN_FIRST = 4'd1;
  localparam logic [HdrIdxW-1:0] HDR_LEN_LAST  = 4'd4;
  localparam logic [HdrIdxW-1:0] HDR_CRC_FIRST = 4'd5;
  localparam logic [HdrIdxW-1:0] HDR_CRC_LAST  = 4'd8;
  localparam logic [HdrIdxW-1:0] HDR_TS_FIRST  = 4'd9;
  localparam logic [HdrIdxW-1:0] HDR_TS_LAST   = 4'd10;
  localparam logic [HdrIdxW-1:0] HDR_PAD       = 4'(HdrBytes - 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;
  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        byte_valid;
    logic        frame_end;
    logic        crc_check;
    logic [1:0]  status;
    logic [7:0]  pkt_type;
    logic [31:0] pkt_length;
    logic [15:0] pkt_stamp;
    logic [31:0] exp_crc;
  } item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/pdc_front.sv]
// Front end: parses the 12-byte header, tracks the payload count and classifies each byte.
// Pushes one pdc_pkg::item_t per result into the queue; depends on pdc_pkg.
`timescale 1ns / 1ps

module pdc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output pdc_pkg::item_t     q_item_o
);

  logic [15:0]                  max_q;
  logic                         in_pay_q, in_pay_d;
  logic [pdc_pkg::HdrIdxW-1:0]  idx_q, idx_d;
  logic [15:0]                  left_q, left_d;
  logic [7:0]                   type_q, type_d;
  logic [31:0]                  len_q, len_d;
  logic [31:0]                  crc_q, crc_d;
  logic [15:0]                  stamp_q, stamp_d;
  logic                         acc;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && !q_full_i;

  always_comb begin
    in_pay_d = in_pay_q;
    idx_d    = idx_q;
    left_d   = left_q;
    type_d   = type_q;
    len_d    = len_q;
    crc_d    = crc_q;
    stamp_d  = stamp_q;
    q_push_o = 1'b0;
    q_item_o = '{data: 8'd0, byte_valid: 1'b0, frame_end: 1'b0, crc_check: 1'b0,
                 status: pdc_pkg::ST_OK, pkt_type: type_q, pkt_length: len_q,
                 pkt_stamp: stamp_q, exp_crc: crc_q};
    if (acc) begin
      if (in_pay_q) begin
        q_push_o            = 1'b1;
        q_item_o.data       = in_byte_i;
        q_item_o.byte_valid = 1'b1;
        left_d              = left_q - 16'd1;
        if (left_q == 16'd1) begin
          q_item_o.frame_end = 1'b1;
          q_item_o.crc_check = 1'b1;
          in_pay_d           = 1'b0;
        end
      end else begin
        case (idx_q) inside
          pdc_pkg::HDR_TYPE: begin
            type_d = in_byte_i;
          end
          [pdc_pkg::HDR_LEN_FIRST:pdc_pkg::HDR_LEN_LAST]: begin
            len_d = {len_q[23:0], in_byte_i};
          end
          [pdc_pkg::HDR_CRC_FIRST:pdc_pkg::HDR_CRC_LAST]: begin
            crc_d = {crc_q[23:0], in_byte_i};
          end
          [pdc_pkg::HDR_TS_FIRST:pdc_pkg::HDR_TS_LAST]: begin
            stamp_d = {stamp_q[7:0], in_byte_i};
          end
          default: ;
        endcase
        if (idx_q == pdc_pkg::HDR_PAD) begin
          idx_d = pdc_pkg::HDR_TYPE;
          if (len_q > {16'd0, max_q}) begin
            q_push_o           = 1'b1;
            q_item_o.frame_end = 1'b1;
            q_item_o.status    = pdc_pkg::ST_TOO_LONG;
          end else if (len_q == 32'd0) begin
            q_push_o           = 1'b1;
            q_item_o.frame_end = 1'b1;
            q_item_o.status    = (crc_q == 32'd0) ? pdc_pkg::ST_OK : pdc_pkg::ST_CRC_BAD;
          end else begin
            in_pay_d = 1'b1;
            left_d   = len_q[15:0];
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= pdc_pkg::MAX_PAYLOAD_RST;
      in_pay_q <= 1'b0;
      idx_q    <= pdc_pkg::HDR_TYPE;
      left_q   <= 16'd0;
      type_q   <= 8'd0;
      len_q    <= 32'd0;
      crc_q    <= 32'd0;
      stamp_q  <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      in_pay_q <= in_pay_d;
      idx_q    <= idx_d;
      left_q   <= left_d;
      type_q   <= type_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      stamp_q  <= stamp_d;
    end
  end

endmodule

[hw/rtl/pdc_queue.sv]
// Two-entry queue of classified items between the front and the back.
// Depends on pdc_pkg for the entry type.
`timescale 1ns / 1ps

module pdc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdc_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pdc_pkg::item_t pop_item_o
);

  pdc_pkg::item_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/pdc_back.sv]
// Back end: runs the CRC-32 over payload bytes, settles the status and holds the result register.
// Depends on pdc_pkg for the item type, status codes and CRC update.
`timescale 1ns / 1ps

module pdc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  pdc_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pdc_pkg::item_t out_item_o
);

  logic           out_valid_q;
  pdc_pkg::item_t out_q, out_d;
  logic [31:0]    crc_q, crc_d, crc_upd;
  logic           take;

  assign take        = !out_valid_q || out_ready_i;
  assign q_pop_o     = q_valid_i && take;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign crc_upd     = pdc_pkg::crc_byte(crc_q, q_item_i.data);

  always_comb begin
    crc_d = crc_q;
    out_d = q_item_i;
    if (q_pop_o && q_item_i.byte_valid) begin
      crc_d = q_item_i.frame_end ? pdc_pkg::CRC_INIT : crc_upd;
    end
    if (q_item_i.crc_check) begin
      out_d.status = ((crc_upd ^ pdc_pkg::CRC_INIT) == q_item_i.exp_crc) ?
                     pdc_pkg::ST_OK : pdc_pkg::ST_CRC_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= pdc_pkg::CRC_INIT;
    end else begin
      if (take) begin
        out_valid_q <= q_valid_i;
      end
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

[hw/rtl/packet_deframer_crc32_check.sv]
// Deframes back-to-back length-prefixed frames (12-byte header, then payload) from a byte
// stream, passes payload bytes out and checks each frame's CRC-32 (reflected, IEEE). One byte
// is taken per clock cycle while the queue is not full; a result passes through the queue and
// the output register, with a single bytewise CRC update in the back end. Header bytes give
// no result; a frame closes on its last payload byte, or on the last header byte when the
// length is zero or above max_payload. A two-entry queue and an output register decouple the
// parser from the CRC stage and the downstream sink. Top level; depends on pdc_pkg,
// pdc_front, pdc_queue and pdc_back.
`timescale 1ns / 1ps

module packet_deframer_crc32_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,       // max_payload
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,      // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,      // [7:0] out_byte, [9:8] status, [17:10] pkt_type,
                                         // [49:18] pkt_length, [65:50] pkt_stamp, rest zero
  output logic        m_axis_tuser,      // [0] byte_valid
  output logic        m_axis_tlast       // frame_end
);

  logic           push, full, pop, q_valid;
  pdc_pkg::item_t push_item, pop_item, out_item;

  pdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_item_o    (push_item)
  );

  pdc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  pdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {6'd0, out_item.pkt_stamp, out_item.pkt_length, out_item.pkt_type,
                         out_item.status, out_item.data};
  assign m_axis_tuser = out_item.byte_valid;
  assign m_axis_tlast = out_item.frame_end;

endmodule

[tb/tb_packet_deframer_crc32_check.sv]
// Testbench for packet_deframer_crc32_check: streams back-to-back frames with random gaps and
// stalls on both sides, predicts each output transfer in-line and checks it field by field.
// Depends on pdc_pkg and the packet_deframer_crc32_check RTL.
`timescale 1ns / 1ps

module tb_packet_deframer_crc32_check;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic [1:0]  status;
    logic [7:0]  ftype;
    logic [31:0] flen;
    logic [15:0] fstamp;
  } deframed_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  logic [7:0] rx_bytes_q [$];
  deframed_t  deframed_q [$];
  int         mismatch_cnt = 0;
  int         rx_pushed    = 0;

  // driver / sink pacing
  bit byte_taken = 1'b0;
  bit res_taken  = 1'b0;
  bit in_calm    = 1'b0;
  bit out_calm   = 1'b0;
  int in_gap     = 0;
  int out_stall  = 0;

  // deframer model state
  logic [15:0] max_len   = pdc_pkg::MAX_PAYLOAD_RST;
  logic        in_body   = 1'b0;
  logic [3:0]  hdr_pos   = pdc_pkg::HDR_TYPE;
  logic [7:0]  hdr_type  = '0;
  logic [31:0] hdr_len   = '0;
  logic [31:0] hdr_crc   = '0;
  logic [15:0] hdr_stamp = '0;
  logic [31:0] body_left = '0;
  logic [31:0] body_crc  = pdc_pkg::CRC_INIT;

  packet_deframer_crc32_check i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // bit-serial reflected CRC-32, LSB first
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ ((c[0] ^ b[k]) ? pdc_pkg::CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    deframed_t r;
    bit        emit;
    r    = '0;
    emit = 1'b0;
    if (in_body) begin
      body_crc  = crc32_step(body_crc, b);
      body_left = body_left - 1;
      emit      = 1'b1;
      r.data    = b;
      r.valid   = 1'b1;
      if (body_left == 0) begin
        in_body  = 1'b0;
        hdr_pos  = pdc_pkg::HDR_TYPE;
        r.last   = 1'b1;
        r.status = ((body_crc ^ pdc_pkg::CRC_INIT) == hdr_crc) ?
                   pdc_pkg::ST_OK : pdc_pkg::ST_CRC_BAD;
      end
    end else begin
      if (hdr_pos == pdc_pkg::HDR_TYPE) hdr_type = b;
      else if (hdr_pos <= pdc_pkg::HDR_LEN_LAST) hdr_len = {hdr_len[23:0], b};
      else if (hdr_pos <= pdc_pkg::HDR_CRC_LAST) hdr_crc = {hdr_crc[23:0], b};
      else if (hdr_pos <= pdc_pkg::HDR_TS_LAST) hdr_stamp = {hdr_stamp[7:0], b};
      if (hdr_pos != pdc_pkg::HDR_PAD) begin
        hdr_pos = hdr_pos + 1'b1;
      end else begin
        hdr_pos = pdc_pkg::HDR_TYPE;
        emit    = 1'b1;
        r.last  = 1'b1;
        if (hdr_len > max_len) begin
          r.status = pdc_pkg::ST_TOO_LONG;
        end else if (hdr_len == 0) begin
          r.status = (hdr_crc == 0) ? pdc_pkg::ST_OK : pdc_pkg::ST_CRC_BAD;
        end else begin
          emit      = 1'b0;
          in_body   = 1'b1;
          body_left = hdr_len;
          body_crc  = pdc_pkg::CRC_INIT;
        end
      end
    end
    if (emit) begin
      r.ftype  = hdr_type;
      r.flen   = hdr_len;
      r.fstamp = hdr_stamp;
      deframed_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    deframed_t e;
    if (deframed_q.size() == 0) begin
      $display("%0t: unexpected transfer, expected none, actual tdata=%h tuser=%b tlast=%b",
               $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      mismatch_cnt++;
    end else begin
      e = deframed_q.pop_front();
      check_field("out_byte", e.data, m_axis_tdata[7:0]);
      check_field("status", e.status, m_axis_tdata[9:8]);
      check_field("pkt_type", e.ftype, m_axis_tdata[17:10]);
      check_field("pkt_length", e.flen, m_axis_tdata[49:18]);
      check_field("pkt_stamp", e.fstamp, m_axis_tdata[65:50]);
      check_field("tdata pad", 32'h0, m_axis_tdata[71:66]);
      check_field("byte_valid", e.valid, m_axis_tuser);
      check_field("frame_end", e.last, m_axis_tlast);
    end
  endtask

  always @(posedge clk_i) begin
    byte_taken = s_axis_tvalid && s_axis_tready;
    res_taken  = m_axis_tvalid && m_axis_tready;
    if (byte_taken) deframe_byte(s_axis_tdata);
    if (res_taken) check_result();
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || byte_taken)) begin
      if (byte_taken) begin
        if ($urandom_range(0, 40) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 5);
      end
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() > 0) begin
        s_axis_tdata  <= rx_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output sink
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        if ($urandom_range(0, 40) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 5);
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    rx_pushed++;
  endtask

  // header plus payload; a length above the current limit gets no payload
  task automatic add_frame(input logic [7:0] ftype, input logic [31:0] flen,
                           input logic [15:0] stamp, input bit corrupt);
    logic [31:0] crc;
    logic [7:0]  body [$];
    crc = pdc_pkg::CRC_INIT;
    if (flen <= max_len) begin
      for (int unsigned i = 0; i < flen; i++) begin
        body.push_back(8'($urandom));
        crc = crc32_step(crc, body[i]);
      end
    end
    crc = crc ^ pdc_pkg::CRC_INIT;
    if (corrupt) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    push_byte(ftype);
    for (int i = 3; i >= 0; i--) push_byte(flen[8*i +: 8]);
    for (int i = 3; i >= 0; i--) push_byte(crc[8*i +: 8]);
    push_byte(stamp[15:8]);
    push_byte(stamp[7:0]);
    push_byte(8'($urandom));
    foreach (body[i]) push_byte(body[i]);
  endtask

  task automatic wait_drained();
    while (rx_bytes_q.size() != 0 || s_axis_tvalid || deframed_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_max_len(input logic [15:0] v);
    wait_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    max_len = v;
  endtask

  task automatic add_random_frame();
    int          sel;
    int unsigned lim;
    sel = $urandom_range(0, 99);
    lim = (max_len < 24) ? max_len : 24;
    if (sel < 70) begin
      add_frame(8'($urandom), $urandom_range(0, lim), 16'($urandom), 1'b0);
    end else if (sel < 80) begin
      add_frame(8'($urandom), $urandom_range(0, lim), 16'($urandom), 1'b1);
    end else if (sel < 88) begin
      lim = (max_len < 80) ? max_len : 80;
      add_frame(8'($urandom), $urandom_range(0, lim), 16'($urandom), 1'($urandom));
    end else if (sel < 95) begin
      add_frame(8'($urandom), 32'(max_len) + 1 + $urandom_range(0, 200), 16'($urandom),
                1'($urandom));
    end else begin
      add_frame(8'($urandom), $urandom | 32'h0001_0000, 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: limit at reset value
    add_frame(8'h00, 0, 16'h0000, 1'b0);
    add_frame(8'hFF, 0, 16'hFFFF, 1'b1);
    add_frame(8'hA5, 1, 16'h1234, 1'b0);
    add_frame(8'h5A, 1, 16'h8001, 1'b1);
    add_frame(8'h01, 40, 16'h00FF, 1'b0);
    add_frame(8'h02, 4097, 16'hFF00, 1'b0);
    add_frame(8'h03, 32'hFFFF_FFFF, 16'h5555, 1'b1);
    add_frame(8'h04, 3, 16'hAAAA, 1'b0);
    set_max_len(16'd0);
    add_frame(8'h10, 0, 16'h0001, 1'b0);
    add_frame(8'h11, 1, 16'h0002, 1'b0);
    add_frame(8'h12, 0, 16'h0003, 1'b1);
    set_max_len(16'hFFFF);
    add_frame(8'h20, 32'h0001_0000, 16'h0004, 1'b0);
    add_frame(8'h21, 32'h8000_0000, 16'h0005, 1'b0);
    add_frame(8'h22, 5, 16'h0006, 1'b0);
    set_max_len(16'd1);
    add_frame(8'h30, 1, 16'h0007, 1'b0);
    add_frame(8'h31, 2, 16'h0008, 1'b0);

    // random phases, each with its own limit
    while (rx_pushed < 1150) begin
      case ($urandom_range(0, 3))
        0: set_max_len(16'($urandom_range(0, 8)));
        1: set_max_len(16'($urandom_range(9, 64)));
        2: set_max_len(16'hFFFF);
        default: set_max_len(16'($urandom));
      endcase
      repeat (12) add_random_frame();
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
